/* rtl/icc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_pkg - shared types and codes for the ISDN call control block
// Command, message and media action codes, the call phase type and the
// structs that carry call state and one result between modules.
// ----------------------------------------------------------------------------
package icc_pkg;

  // Command and event codes
  localparam logic [3:0] CMD_MAKE_CALL    = 4'd0;
  localparam logic [3:0] CMD_HANG_UP      = 4'd1;
  localparam logic [3:0] CMD_PROCEEDING   = 4'd2;
  localparam logic [3:0] CMD_ALERTING     = 4'd3;
  localparam logic [3:0] CMD_CONNECT_IND  = 4'd4;
  localparam logic [3:0] CMD_CONNECT_CONF = 4'd5;
  localparam logic [3:0] CMD_CLEAR_IND    = 4'd6;
  localparam logic [3:0] CMD_CLEAR_CONF   = 4'd7;
  localparam logic [3:0] CMD_RELEASE_CH   = 4'd8;

  // Outgoing message codes
  localparam logic [2:0] SEND_NONE     = 3'd0;
  localparam logic [2:0] SEND_CONN_RQ  = 3'd1;
  localparam logic [2:0] SEND_CONN_RS  = 3'd2;
  localparam logic [2:0] SEND_CLEAR_RQ = 3'd3;
  localparam logic [2:0] SEND_CLEAR_RS = 3'd4;

  // Media actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // Cause used for a clear request after an unexpected event
  localparam logic [6:0] CAUSE_UNEXPECTED = 7'd0;
  // Reset value of the hang-up cause register
  localparam logic [6:0] HANGUP_CAUSE_RESET = 7'd16;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WAIT_CONN  = 2'd1,
    PH_ACTIVE     = 2'd2,
    PH_WAIT_CLEAR = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       outbound;
    logic       bound;
    logic [4:0] channel;
  } call_state_t;

  typedef struct packed {
    logic [4:0] bound_channel;
    logic       bound_valid;
    logic       is_outbound;
    logic [1:0] call_state;
    logic       call_failed;
    logic       wrong_state;
    logic [1:0] channel_action;
    logic [4:0] send_channel;
    logic [6:0] send_cause;
    logic [2:0] send_code;
  } result_t;

endpackage

/* rtl/icc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_step - call control transition logic
// Combinational: from the current call state and one item, form the next
// call state and the result that goes out for that item.
// ----------------------------------------------------------------------------
module icc_step (
  input  icc_pkg::call_state_t cur,
  input  logic [3:0]           cmd,
  input  logic                 has_channel,
  input  logic [4:0]           channel_number,
  input  logic [6:0]           hangup_cause,
  output icc_pkg::call_state_t nxt,
  output icc_pkg::result_t     res
);
  import icc_pkg::*;

  always_comb begin
    call_state_t st;
    logic [2:0]  send;
    logic [6:0]  cause;
    logic [4:0]  sch;
    logic [1:0]  act;
    logic        wrong;
    logic        failed;
    logic        unexpected;

    st         = cur;
    send       = SEND_NONE;
    cause      = 7'd0;
    sch        = 5'd0;
    act        = ACT_NONE;
    wrong      = 1'b0;
    failed     = 1'b0;
    unexpected = 1'b0;

    case (cmd)
      CMD_MAKE_CALL: begin
        if (cur.phase != PH_IDLE) begin
          wrong = 1'b1;
        end else begin
          st.bound    = 1'b1;
          st.channel  = channel_number;
          st.phase    = PH_WAIT_CONN;
          st.outbound = 1'b1;
          send        = SEND_CONN_RQ;
          sch         = channel_number;
        end
      end
      CMD_HANG_UP: begin
        if (cur.phase != PH_ACTIVE) begin
          wrong = 1'b1;
        end else begin
          st.phase = PH_WAIT_CLEAR;
          if (cur.bound) act = ACT_STOP;
          send  = SEND_CLEAR_RQ;
          cause = hangup_cause;
        end
      end
      CMD_PROCEEDING, CMD_ALERTING: begin
        if (has_channel) begin
          st.bound   = 1'b1;
          st.channel = channel_number;
        end
      end
      CMD_CONNECT_IND: begin
        if (cur.phase != PH_IDLE) begin
          unexpected = 1'b1;
        end else begin
          if (has_channel) begin
            st.bound   = 1'b1;
            st.channel = channel_number;
          end
          st.outbound = 1'b0;
          st.phase    = PH_WAIT_CONN;
          send        = SEND_CONN_RS;
          sch         = st.bound ? st.channel : 5'd0;
        end
      end
      CMD_CONNECT_CONF: begin
        if (cur.phase != PH_WAIT_CONN) begin
          unexpected = 1'b1;
        end else begin
          st.phase = PH_ACTIVE;
          if (has_channel) begin
            st.bound   = 1'b1;
            st.channel = channel_number;
          end
          if (st.bound) act = ACT_START;
        end
      end
      CMD_CLEAR_IND: begin
        // Clear collision: already clearing, do nothing
        if (cur.phase == PH_IDLE) begin
          unexpected = 1'b1;
        end else if (cur.phase != PH_WAIT_CLEAR) begin
          if (cur.phase == PH_ACTIVE && cur.bound) act = ACT_STOP;
          st.phase = PH_WAIT_CLEAR;
          send     = SEND_CLEAR_RS;
        end
      end
      CMD_CLEAR_CONF: begin
        if (cur.phase == PH_IDLE) begin
          unexpected = 1'b1;
        end else if (cur.phase == PH_ACTIVE && cur.bound) begin
          act = ACT_STOP;
        end else if (cur.phase == PH_WAIT_CONN) begin
          failed = 1'b1;
        end
        st.bound    = 1'b0;
        st.channel  = 5'd0;
        st.outbound = 1'b0;
        st.phase    = PH_IDLE;
      end
      CMD_RELEASE_CH: begin
        if (cur.bound && cur.channel == channel_number) begin
          st.bound   = 1'b0;
          st.channel = 5'd0;
        end
      end
      default: begin
      end
    endcase

    // Unexpected event: answer with a clear request carrying cause zero
    if (unexpected) begin
      send  = SEND_CLEAR_RQ;
      cause = CAUSE_UNEXPECTED;
      wrong = 1'b1;
    end

    nxt                = st;
    res.send_code      = send;
    res.send_cause     = cause;
    res.send_channel   = sch;
    res.channel_action = act;
    res.wrong_state    = wrong;
    res.call_failed    = failed;
    res.call_state     = st.phase;
    res.is_outbound    = st.outbound;
    res.bound_valid    = st.bound;
    res.bound_channel  = st.channel;
  end

endmodule

/* rtl/isdn_call_control_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdn_call_control_fsm - per-call ISDN call control machine
// Tracks one call through idle, awaiting connect, active and awaiting
// clearance, and gives one result item for every input item.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------
//   s_*     | in  | s_tvalid / s_tready  | s_tdata: cmd, channel_number;
//           |     |                      | s_tuser: has_channel
//   m_*     | out | m_tvalid / m_tready  | m_tdata: result fields
//   cfg_*   | in  | cfg_valid / cfg_ready| cfg_data: hang-up cause
//
// An item is held in the input register and then in the result register;
// the call state updates as it moves between them, so a new item
// is taken every cycle while the result side keeps up.
// Reset (rst, synchronous) sets the call idle and the hang-up cause to 16.
// When m_tready is low the result holds, the input register fills, and
// s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module isdn_call_control_fsm (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] cmd, [8:4] channel_number, rest zero
  input  logic        s_tuser,   // [0] has_channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] send_code, [9:3] send_cause,
                                 // [14:10] send_channel, [16:15] channel_action,
                                 // [17] wrong_state, [18] call_failed,
                                 // [20:19] call_state, [21] is_outbound,
                                 // [22] bound_valid, [27:23] bound_channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // [6:0] hang-up cause
);
  import icc_pkg::*;

  logic        in_valid;
  logic [3:0]  in_cmd;
  logic        in_has_ch;
  logic [4:0]  in_ch;
  logic        out_valid;
  result_t     out_res;
  logic [6:0]  hangup_cause;
  call_state_t call_st;
  call_state_t call_st_next;
  result_t     step_res;
  logic        advance;

  // Move the held item to the result register when that side has room
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  icc_step u_step (
    .cur            (call_st),
    .cmd            (in_cmd),
    .has_channel    (in_has_ch),
    .channel_number (in_ch),
    .hangup_cause   (hangup_cause),
    .nxt            (call_st_next),
    .res            (step_res)
  );

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_cmd    <= s_tdata[3:0];
      in_ch     <= s_tdata[8:4];
      in_has_ch <= s_tuser;
    end
  end

  // Hold call state and the registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      call_st.phase    <= PH_IDLE;
      call_st.outbound <= 1'b0;
      call_st.bound    <= 1'b0;
      call_st.channel  <= 5'd0;
      out_valid        <= 1'b0;
    end else if (advance) begin
      call_st   <= call_st_next;
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hangup_cause <= HANGUP_CAUSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hangup_cause <= cfg_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_res};

  // Unbound channel always reads as zero
  assert property (@(posedge clk) disable iff (rst)
    !call_st.bound |-> call_st.channel == 5'd0)
    else $error("unbound call state holds a nonzero channel");

  // A failed call ends idle with nothing bound
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.call_failed) |->
      (out_res.call_state == PH_IDLE && !out_res.bound_valid))
    else $error("call_failed reported without return to idle");

  // Media start only on an active call with a bound channel
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.channel_action == ACT_START) |->
      (out_res.call_state == PH_ACTIVE && out_res.bound_valid))
    else $error("media start outside an active bound call");

  // Call state changes only when an item is processed
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(call_st))
    else $error("call state changed without an item");

endmodule
